### src/ats_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, codes and helpers for the alarm slot table with snooze.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int TIME_W      = 32;
  localparam int OP_W        = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 8;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 16;
  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int KEY_W       = HOUR_W + MINUTE_W;

  localparam logic [TIME_W-1:0]  SNOOZE_LEN_RESET = 32'd300000;
  localparam logic [TIME_W-1:0]  AUTO_AFTER_RESET = 32'd60000;
  localparam logic [LIMIT_W-1:0] AUTO_LIMIT_RESET = 8'd3;
  localparam logic [LIMIT_W-1:0] AUTO_COUNT_MAX   = 8'd255;

  localparam logic [7:0] HOURS_PER_DAY    = 8'd24;
  localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
  // x/24 ~= (x*171) >> 12 and x/60 ~= (x*273) >> 14, both never above the
  // true quotient and at most one low for 8-bit x
  localparam logic [16:0] RECIP_24 = 17'd171;
  localparam int          SHIFT_24 = 12;
  localparam logic [16:0] RECIP_60 = 17'd273;
  localparam int          SHIFT_60 = 14;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE  = 3'd0,
    OP_WRITE   = 3'd1,
    OP_DISMISS = 3'd2,
    OP_SNOOZE  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SNOOZE_LEN = 2'd0,
    CFG_AUTO_AFTER = 2'd1,
    CFG_AUTO_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SNZ_CHK,
    ST_SHOW_CHK,
    ST_ELAP_CMP,
    ST_AUTO,
    ST_DIS_RD,
    ST_DISMISS,
    ST_SNOOZE,
    ST_SCAN_START,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                recurring;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } entry_t;

  // x mod 24 by reciprocal multiply plus one correcting subtract
  function automatic logic [HOUR_W-1:0] mod_hours(input logic [7:0] x);
    logic [16:0] p;
    logic [4:0]  q;
    logic [12:0] qd;
    logic [7:0]  r;
    p  = {9'd0, x} * RECIP_24;
    q  = p[16:SHIFT_24];
    qd = {8'd0, q} * {5'd0, HOURS_PER_DAY};
    r  = x - qd[7:0];
    if (r >= HOURS_PER_DAY) r = r - HOURS_PER_DAY;
    return r[HOUR_W-1:0];
  endfunction

  // x mod 60, same scheme
  function automatic logic [MINUTE_W-1:0] mod_minutes(input logic [7:0] x);
    logic [16:0] p;
    logic [2:0]  q;
    logic [10:0] qd;
    logic [7:0]  r;
    p  = {9'd0, x} * RECIP_60;
    q  = p[16:SHIFT_60];
    qd = {8'd0, q} * {3'd0, MINUTES_PER_HOUR};
    r  = x - qd[7:0];
    if (r >= MINUTES_PER_HOUR) r = r - MINUTES_PER_HOUR;
    return r[MINUTE_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/alarm_table_with_snooze.sv
`default_nettype none
// Write, read and unknown opcodes go from dispatch straight to the output state;
//   dismiss and snooze add steps when shown; update adds timer checks or a scan.
// Throughput: one item at a time; next transfer in the cycle after result loads.
//   The scan reads one slot per cycle and all timer math shares one 32-bit adder.
// Reset (rst, synchronous): valid bits, flags, counters and config registers
//   return to defaults at once; no clearing pass, table contents stay stale.
// ----------------------------------------------------------------------------
// alarm_table_with_snooze
// Alarm slot table with show, snooze, auto-snooze and auto-dismiss, run by a
// small sequencer around a shared add/subtract unit.
// ----------------------------------------------------------------------------
module alarm_table_with_snooze #(
  parameter int SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata from bit 0: slot[4], entry_hour[8], entry_minute[8],
  // entry_recurring[1], entry_enable[1], now_ms[32], cur_hour[5],
  // cur_minute[6], time_valid[1], blocked[1], zero pad[5]
  input  logic [ats_pkg::IN_DATA_W-1:0]       s_tdata,
  // tuser: opcode[3]
  input  logic [ats_pkg::OP_W-1:0]            s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata from bit 0: state_changed[1], showing[1], shown_slot[4],
  // snooze_waiting[1], auto_snoozes_done[8], zero pad[1]
  output logic [ats_pkg::OUT_DATA_W-1:0]      m_tdata,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [ats_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ats_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
  localparam int CW  = $clog2(SLOTS + 1);                // valid slot count
  localparam int TW  = ats_pkg::TIME_W;
  localparam int HW  = ats_pkg::HOUR_W;
  localparam int MW  = ats_pkg::MINUTE_W;
  localparam int LW  = ats_pkg::LIMIT_W;
  localparam int KW  = ats_pkg::KEY_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  ats_pkg::state_t state, state_next;

  // config registers
  logic [TW-1:0] snooze_len;
  logic [TW-1:0] auto_after;
  logic [LW-1:0] auto_limit;

  // latched item
  logic [ats_pkg::OP_W-1:0] op;
  logic [3:0]               in_slot;
  logic [7:0]               in_hour;
  logic [7:0]               in_minute;
  logic                     in_rec;
  logic                     in_en;
  logic [TW-1:0]            now;
  logic [HW-1:0]            cur_hr;
  logic [MW-1:0]            cur_mn;
  logic                     tvld;
  logic                     blk;

  // alarm state
  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    nvalid;
  logic             show_flag;
  logic [IW-1:0]    shown_index;
  logic [TW-1:0]    show_start;
  logic             snooze_flag;
  logic [TW-1:0]    snooze_deadline;
  logic [IW-1:0]    snoozed_index;
  logic             last_valid;
  logic [KW-1:0]    last_key;
  logic [LW-1:0]    auto_count;
  logic             change_flag;
  logic             sc;          // state_changed of the item in flight

  // table memory: recurring, hour, minute per slot; valid bits live in flops
  ats_pkg::entry_t mem [SLOTS];
  ats_pkg::entry_t rd_data;
  logic [IW-1:0]   rd_idx;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   scan_i;
  logic            tbl_we;
  ats_pkg::entry_t wr_entry;

  // shared adder
  logic [TW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_borrow;
  logic [TW-1:0] elap;

  logic          out_load;
  logic [IW-1:0] wr_idx;
  logic          slot_ok;
  logic [KW-1:0] key;
  logic          key_seen;
  logic          scan_hit;

  assign wr_idx   = IW'(in_slot);
  assign slot_ok  = (32'(in_slot) < 32'(SLOTS));
  assign key      = {cur_hr, cur_mn};
  assign key_seen = last_valid && (last_key == key);
  assign scan_hit = valid[rd_idx] && (rd_data.hour == cur_hr) && (rd_data.minute == cur_mn)
                    && !(snooze_flag && (snoozed_index == rd_idx));

  assign wr_entry.recurring = in_rec;
  assign wr_entry.hour      = ats_pkg::mod_hours(in_hour);
  assign wr_entry.minute    = ats_pkg::mod_minutes(in_minute);

  ats_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ats_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ats_pkg::ST_DISPATCH;
      end
      ats_pkg::ST_DISPATCH: begin
        case (op)
          ats_pkg::OP_UPDATE: begin
            if (nvalid == '0 && !snooze_flag) state_next = ats_pkg::ST_OUT;
            else if (snooze_flag && !show_flag) state_next = ats_pkg::ST_SNZ_CHK;
            else state_next = ats_pkg::ST_SHOW_CHK;
          end
          ats_pkg::OP_DISMISS: state_next = show_flag ? ats_pkg::ST_DIS_RD : ats_pkg::ST_OUT;
          ats_pkg::OP_SNOOZE:  state_next = show_flag ? ats_pkg::ST_SNOOZE : ats_pkg::ST_OUT;
          default:             state_next = ats_pkg::ST_OUT;
        endcase
      end
      ats_pkg::ST_SNZ_CHK: state_next = ats_pkg::ST_SHOW_CHK;
      ats_pkg::ST_SHOW_CHK: begin
        if (show_flag) state_next = ats_pkg::ST_ELAP_CMP;
        else if (blk || !tvld || key_seen) state_next = ats_pkg::ST_OUT;
        else state_next = ats_pkg::ST_SCAN_START;
      end
      ats_pkg::ST_ELAP_CMP: state_next = alu_borrow ? ats_pkg::ST_OUT : ats_pkg::ST_AUTO;
      ats_pkg::ST_AUTO: begin
        state_next = (auto_count >= auto_limit) ? ats_pkg::ST_DIS_RD : ats_pkg::ST_SNOOZE;
      end
      ats_pkg::ST_DIS_RD:     state_next = ats_pkg::ST_DISMISS;
      ats_pkg::ST_DISMISS:    state_next = ats_pkg::ST_OUT;
      ats_pkg::ST_SNOOZE:     state_next = ats_pkg::ST_OUT;
      ats_pkg::ST_SCAN_START: state_next = ats_pkg::ST_SCAN;
      ats_pkg::ST_SCAN: begin
        if (scan_hit || rd_idx == LAST_IDX) state_next = ats_pkg::ST_OUT;
      end
      ats_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ats_pkg::ST_IDLE;
      end
      default: state_next = ats_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: adder operands, table port, handshake
  always_comb begin
    s_tready = (state == ats_pkg::ST_IDLE);
    out_load = (state == ats_pkg::ST_OUT) && (!m_tvalid || m_tready);
    tbl_we   = (state == ats_pkg::ST_DISPATCH) && (op == ats_pkg::OP_WRITE) && slot_ok && in_en;
    alu_a    = now;
    alu_b    = show_start;
    alu_sub  = 1'b1;
    rd_addr  = scan_i;
    case (state)
      ats_pkg::ST_SNZ_CHK: alu_b = snooze_deadline;          // deadline reached?
      ats_pkg::ST_ELAP_CMP: begin                            // shown long enough?
        alu_a = elap;
        alu_b = auto_after;
      end
      ats_pkg::ST_SNOOZE: begin                              // new deadline
        alu_b   = snooze_len;
        alu_sub = 1'b0;
      end
      ats_pkg::ST_DIS_RD:     rd_addr = shown_index;         // fetch recurring bit
      ats_pkg::ST_SCAN_START: rd_addr = '0;
      default: ;
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (tbl_we) mem[wr_idx] <= wr_entry;
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  // item capture and scratch, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op        <= s_tuser;
      in_slot   <= s_tdata[3:0];
      in_hour   <= s_tdata[11:4];
      in_minute <= s_tdata[19:12];
      in_rec    <= s_tdata[20];
      in_en     <= s_tdata[21];
      now       <= s_tdata[53:22];
      cur_hr    <= s_tdata[58:54];
      cur_mn    <= s_tdata[64:59];
      tvld      <= s_tdata[65];
      blk       <= s_tdata[66];
    end
    if (state == ats_pkg::ST_SHOW_CHK) elap <= alu_res;
    if (state == ats_pkg::ST_SCAN_START) scan_i <= IW'(1);
    else if (state == ats_pkg::ST_SCAN && !scan_hit && rd_idx != LAST_IDX)
      scan_i <= scan_i + IW'(1);
    if (out_load) begin
      m_tdata <= {1'b0, auto_count, snooze_flag,
                  show_flag ? 4'(shown_index) : 4'd0, show_flag, sc};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ats_pkg::ST_IDLE;
      snooze_len      <= ats_pkg::SNOOZE_LEN_RESET;
      auto_after      <= ats_pkg::AUTO_AFTER_RESET;
      auto_limit      <= ats_pkg::AUTO_LIMIT_RESET;
      valid           <= '0;
      nvalid          <= '0;
      show_flag       <= 1'b0;
      shown_index     <= '0;
      show_start      <= '0;
      snooze_flag     <= 1'b0;
      snooze_deadline <= '0;
      snoozed_index   <= '0;
      last_valid      <= 1'b0;
      last_key        <= '0;
      auto_count      <= '0;
      change_flag     <= 1'b0;
      sc              <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        case (cfg_index)
          ats_pkg::CFG_SNOOZE_LEN: snooze_len <= cfg_data;
          ats_pkg::CFG_AUTO_AFTER: auto_after <= cfg_data;
          ats_pkg::CFG_AUTO_LIMIT: auto_limit <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        ats_pkg::ST_DISPATCH: begin
          sc <= 1'b0;
          case (op)
            ats_pkg::OP_WRITE: begin
              if (slot_ok) begin
                if (in_en) begin
                  valid[wr_idx] <= 1'b1;
                  if (!valid[wr_idx]) nvalid <= nvalid + CW'(1);
                end else if (valid[wr_idx]) begin
                  valid[wr_idx] <= 1'b0;
                  nvalid        <= nvalid - CW'(1);
                  // clearing the shown slot ends the show
                  if (show_flag && shown_index == wr_idx) begin
                    show_flag   <= 1'b0;
                    shown_index <= '0;
                    change_flag <= 1'b1;
                  end
                end
              end
            end
            ats_pkg::OP_READ: begin
              sc          <= change_flag;
              change_flag <= 1'b0;
            end
            default: ;
          endcase
        end
        ats_pkg::ST_SNZ_CHK: begin
          // deadline reached when now - deadline is below 2^31
          if (!alu_res[TW-1] && valid[snoozed_index] && !blk) begin
            show_flag       <= 1'b1;
            shown_index     <= snoozed_index;
            show_start      <= now;
            snooze_flag     <= 1'b0;
            snooze_deadline <= '0;
            snoozed_index   <= '0;
            sc              <= 1'b1;
          end
        end
        ats_pkg::ST_SHOW_CHK: begin
          if (!show_flag && !blk && tvld && !key_seen) begin
            last_valid <= 1'b1;
            last_key   <= key;
          end
        end
        ats_pkg::ST_ELAP_CMP: begin
          if (!alu_borrow) begin
            sc <= 1'b1;
            if (auto_count != ats_pkg::AUTO_COUNT_MAX) auto_count <= auto_count + LW'(1);
          end
        end
        ats_pkg::ST_DISMISS: begin
          if (!rd_data.recurring && valid[shown_index]) begin
            valid[shown_index] <= 1'b0;
            nvalid             <= nvalid - CW'(1);
          end
          show_flag       <= 1'b0;
          shown_index     <= '0;
          snooze_flag     <= 1'b0;
          snooze_deadline <= '0;
          snoozed_index   <= '0;
          auto_count      <= '0;
          change_flag     <= 1'b1;
        end
        ats_pkg::ST_SNOOZE: begin
          snoozed_index   <= shown_index;
          snooze_deadline <= alu_res;
          snooze_flag     <= 1'b1;
          show_flag       <= 1'b0;
          shown_index     <= '0;
          change_flag     <= 1'b1;
        end
        ats_pkg::ST_SCAN: begin
          // lowest matching slot wins: slots are checked in ascending order
          if (scan_hit) begin
            show_flag   <= 1'b1;
            shown_index <= rd_idx;
            show_start  <= now;
            auto_count  <= '0;
            sc          <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // running count must track the valid bits
  a_nvalid_count: assert property (@(posedge clk) disable iff (rst)
    nvalid == CW'($countones(valid)))
    else $error("valid slot count out of step with valid bits");

  // a shown alarm always sits in a live slot
  a_shown_valid: assert property (@(posedge clk) disable iff (rst)
    show_flag |-> valid[shown_index])
    else $error("shown slot is not valid");

  a_snooze_clear: assert property (@(posedge clk) disable iff (rst)
    !snooze_flag |-> (snoozed_index == '0 && snooze_deadline == '0))
    else $error("snooze fields left set without a snooze");

  a_shown_clear: assert property (@(posedge clk) disable iff (rst)
    !show_flag |-> (shown_index == '0))
    else $error("shown index left set while nothing is shown");

endmodule
`default_nettype wire

### src/ats_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_alu
// Shared 32-bit add/subtract unit for timer deadlines and elapsed checks.
// ----------------------------------------------------------------------------
module ats_alu (
  input  logic [ats_pkg::TIME_W-1:0] a,
  input  logic [ats_pkg::TIME_W-1:0] b,
  input  logic                       sub,
  output logic [ats_pkg::TIME_W-1:0] res,
  output logic                       borrow
);

  localparam int W = ats_pkg::TIME_W;

  logic [W:0] sum;

  // one adder; subtract is a + ~b + 1
  assign sum    = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
  assign res    = sum[W-1:0];
  assign borrow = sub & ~sum[W];

endmodule
`default_nettype wire
